FILE: design/rsgm_pkg.sv
// rsgm_pkg: shared types and constants for the rgb sobel gradient magnitude block
// used by rsgm_line_store, rsgm_grad_unit and rgb_sobel_gradient_magnitude_top
// no dependencies
package rsgm_pkg;

    localparam int PIX_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int TOTAL_W = 12;
    localparam int DIV_W   = 10;
    localparam int EDGE_W  = 8;
    localparam int CROW_W  = 12;
    localparam int CCOL_W  = 11;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DIVISOR      = 2'd2;

    // top level sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_WAIT,
        S_PUSH
    } t_state;

    // divide and root unit phases
    typedef enum logic [2:0] {
        DS_IDLE,
        DS_DIV,
        DS_MUL,
        DS_SQRT,
        DS_DONE
    } t_ds_phase;

    // request to the divide and root unit
    typedef struct packed {
        logic               start;
        logic [TOTAL_W-1:0] h_total;
        logic [TOTAL_W-1:0] v_total;
        logic [DIV_W-1:0]   divisor;
    } t_grad_req;

    // response from the divide and root unit
    typedef struct packed {
        logic              done;
        logic [EDGE_W-1:0] edge_value;
    } t_grad_rsp;

endpackage

FILE: design/rsgm_line_store.sv
// rsgm_line_store: the two line stores held in one synchronous memory
// read at the accepted column, written back in the following cycle; uses rsgm_pkg
// upper half holds the pixel from two rows back, lower half the previous row
module rsgm_line_store #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  logic [rsgm_pkg::PIX_W-1:0]  i_px,
    output logic [rsgm_pkg::PIX_W-1:0]  o_upper,
    output logic [rsgm_pkg::PIX_W-1:0]  o_middle
);
    import rsgm_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rdata;
    logic [AW-1:0]      r_addr;
    logic [PIX_W-1:0]   r_px;
    logic               r_wr;

    // read port and held address and pixel for the write back
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_addr];
            r_addr  <= i_addr;
            r_px    <= i_px;
        end
    end

    // write back: previous row moves up, new pixel becomes the previous row
    always_ff @(posedge i_clk) begin
        if (r_wr) begin
            r_mem[r_addr] <= {r_rdata[PIX_W-1:0], r_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
        end else begin
            r_wr <= i_rd_en;
        end
    end

    assign o_upper  = r_rdata[2*PIX_W-1:PIX_W];
    assign o_middle = r_rdata[PIX_W-1:0];

endmodule

FILE: design/rsgm_grad_unit.sv
// rsgm_grad_unit: divides both gradient totals by the divisor (restoring, one bit
// a cycle), forms h*h+v*v and takes the saturated integer square root bit by bit
// uses rsgm_pkg
module rsgm_grad_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsgm_pkg::t_grad_req i_req,
    output rsgm_pkg::t_grad_rsp o_rsp
);
    import rsgm_pkg::*;

    t_ds_phase          r_phase, n_phase;
    logic [3:0]         r_cnt;
    logic [TOTAL_W-1:0] r_hq, r_vq;
    logic [DIV_W-1:0]   r_hr, r_vr;
    logic [DIV_W-1:0]   r_div;
    logic [24:0]        r_energy;
    logic [EDGE_W-1:0]  r_root;
    logic [EDGE_W-1:0]  r_bit;

    logic [DIV_W:0]     h_sh, v_sh;
    logic               h_ge, v_ge;
    logic [EDGE_W-1:0]  trial;
    logic [15:0]        trial_sq;
    logic               sat;

    // one restoring division step for each total
    always_comb begin
        h_sh     = {r_hr, r_hq[TOTAL_W-1]};
        v_sh     = {r_vr, r_vq[TOTAL_W-1]};
        h_ge     = h_sh >= {1'b0, r_div};
        v_ge     = v_sh >= {1'b0, r_div};
        trial    = r_root | r_bit;
        trial_sq = trial * trial;
        sat      = r_energy[24:16] != '0;
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            DS_IDLE: if (i_req.start) n_phase = DS_DIV;
            DS_DIV:  if (r_cnt == 4'd0) n_phase = DS_MUL;
            DS_MUL:  n_phase = DS_SQRT;
            DS_SQRT: if (sat || r_bit[0]) n_phase = DS_DONE;
            DS_DONE: n_phase = DS_IDLE;
            default: n_phase = DS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= DS_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            DS_IDLE: begin
                r_hq   <= i_req.h_total;
                r_vq   <= i_req.v_total;
                r_hr   <= '0;
                r_vr   <= '0;
                r_div  <= (i_req.divisor == '0) ? DIV_W'(1) : i_req.divisor;
                r_cnt  <= 4'(TOTAL_W - 1);
            end
            DS_DIV: begin
                r_hr  <= h_ge ? DIV_W'(h_sh - {1'b0, r_div}) : h_sh[DIV_W-1:0];
                r_vr  <= v_ge ? DIV_W'(v_sh - {1'b0, r_div}) : v_sh[DIV_W-1:0];
                r_hq  <= {r_hq[TOTAL_W-2:0], h_ge};
                r_vq  <= {r_vq[TOTAL_W-2:0], v_ge};
                r_cnt <= r_cnt - 4'd1;
            end
            DS_MUL: begin
                r_energy <= 25'(r_hq * r_hq) + 25'(r_vq * r_vq);
                r_root   <= '0;
                r_bit    <= 8'h80;
            end
            DS_SQRT: begin
                if (sat) begin
                    r_root <= 8'hFF;
                end else if (trial_sq <= r_energy[15:0]) begin
                    r_root <= trial;
                end
                r_bit <= r_bit >> 1;
            end
            DS_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_rsp.done       = r_phase == DS_DONE;
        o_rsp.edge_value = r_root;
    end

endmodule

FILE: design/rgb_sobel_gradient_magnitude_top.sv
// rgb_sobel_gradient_magnitude_top: counters, 3x3 window, sobel sums and output
// register; uses rsgm_pkg, rsgm_line_store and rsgm_grad_unit
//
// Usage:
//   s_axis carries one rgb pixel per transfer in raster order, tdata holds red,
//   green, blue; tuser is frame_start, which clears row and column first.
//   m_axis gives one result for each pixel at row >= 2 and column >= 2, the edge
//   value for the window centred one row up and one column left.
//   The cfg channel writes image width (0), image height (1) and divisor (2);
//   always ready; the user writes it only while the block is idle, not enforced.
// Throughput: one pixel at a time. A pixel with no result passes through read
//   and back to idle before the next transfer. A pixel with a result runs through
//   memory read, sum, start, 12 division steps, multiply, 8 root steps, done,
//   push and idle, the root steps ending after the first when the energy
//   saturates; the bit-serial divider and root unit set the pace.
// Output: tvalid on m_axis rises once the result is pushed into the output
//   register, later while an earlier result still waits.
// Reset: counters and window clear, registers load 640, 480 and 12; line store
//   contents are undefined until written.
// Stall: the result sits in the output register; the next pixel is still taken
//   and its result waits inside until the output register frees.
module rgb_sobel_gradient_magnitude_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        s_axis_tuser,   // frame_start [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // edge_value [7:0], center_row [19:8],
                                        // center_col [30:20], zero [31]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import rsgm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int XW = 18;

    t_state               r_state, n_state;
    logic [11:0]          r_image_width;
    logic [12:0]          r_image_height;
    logic [DIV_W-1:0]     r_divisor;
    logic [CW-1:0]        r_col;
    logic [RW-1:0]        r_row;
    logic [PIX_W-1:0]     r_win [9];
    logic [PIX_W-1:0]     r_px;
    logic                 r_emit;
    logic [CROW_W-1:0]    r_crow;
    logic [CCOL_W-1:0]    r_ccol;
    logic                 r_out_valid;
    logic [EDGE_W-1:0]    r_out_edge;
    logic [CROW_W-1:0]    r_out_row;
    logic [CCOL_W-1:0]    r_out_col;
    logic [TOTAL_W-1:0]   r_ht, r_vt;
    logic                 r_start_pending;

    logic                 accept;
    logic [CW-1:0]        col_eff;
    logic [RW-1:0]        row_eff;
    logic [XW-1:0]        w_lim, h_lim;
    logic [PIX_W-1:0]     ls_upper, ls_middle;
    logic [TOTAL_W-1:0]   ht_sum, vt_sum;
    logic                 out_free;
    t_grad_req            req;
    t_grad_rsp            rsp;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 12'd640;
            r_image_height <= 13'd480;
            r_divisor      <= 10'd12;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[11:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                CFG_DIVISOR:      r_divisor      <= i_cfg_data[DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // geometry clamped to the supported range
    always_comb begin
        w_lim = XW'(r_image_width);
        if (w_lim < XW'(3)) w_lim = XW'(3);
        if (w_lim > XW'(MAX_WIDTH)) w_lim = XW'(MAX_WIDTH);
        h_lim = XW'(r_image_height);
        if (h_lim < XW'(3)) h_lim = XW'(3);
        if (h_lim > XW'(MAX_HEIGHT)) h_lim = XW'(MAX_HEIGHT);
    end

    assign col_eff = s_axis_tuser ? '0 : r_col;
    assign row_eff = s_axis_tuser ? '0 : r_row;

    // position counters and per-item bookkeeping at the input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_emit <= 1'b0;
        end else if (accept) begin
            r_emit <= (row_eff >= RW'(2)) && (col_eff >= CW'(2));
            if (XW'(col_eff) >= w_lim - XW'(1)) begin
                r_col <= '0;
                if (XW'(row_eff) >= h_lim - XW'(1)) begin
                    r_row <= '0;
                end else begin
                    r_row <= row_eff + RW'(1);
                end
            end else begin
                r_col <= col_eff + CW'(1);
                r_row <= row_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px   <= s_axis_tdata;
            r_crow <= CROW_W'(row_eff - RW'(1));
            r_ccol <= CCOL_W'(col_eff - CW'(1));
        end
    end

    rsgm_line_store #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_addr  (col_eff),
        .i_px    (s_axis_tdata),
        .o_upper (ls_upper),
        .o_middle(ls_middle)
    );

    // window shift when the line store data arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_state == S_READ) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= ls_upper;
            r_win[5] <= ls_middle;
            r_win[8] <= r_px;
        end
    end

    // sobel sums per channel, absolute values added over the channels
    always_comb begin
        logic [9:0] xp, xn, yp, yn;
        logic [7:0] p [9];
        ht_sum = '0;
        vt_sum = '0;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 9; i++) begin
                p[i] = r_win[i][k*CHAN_W +: CHAN_W];
            end
            xp = 10'(p[0]) + {1'b0, p[3], 1'b0} + 10'(p[6]);
            xn = 10'(p[2]) + {1'b0, p[5], 1'b0} + 10'(p[8]);
            yp = 10'(p[0]) + {1'b0, p[1], 1'b0} + 10'(p[2]);
            yn = 10'(p[6]) + {1'b0, p[7], 1'b0} + 10'(p[8]);
            ht_sum = ht_sum + TOTAL_W'((xp >= xn) ? xp - xn : xn - xp);
            vt_sum = vt_sum + TOTAL_W'((yp >= yn) ? yp - yn : yn - yp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            r_ht <= ht_sum;
            r_vt <= vt_sum;
        end
    end

    // start the divide and root unit in the cycle after the sum state, with the registered sums
    always_comb begin
        req.start   = r_state == S_WAIT && r_start_pending;
        req.h_total = r_ht;
        req.v_total = r_vt;
        req.divisor = r_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pending <= 1'b0;
        end else begin
            r_start_pending <= r_state == S_SUM;
        end
    end

    rsgm_grad_unit u_grad_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_READ;
            S_READ: n_state = r_emit ? S_SUM : S_IDLE;
            S_SUM:  n_state = S_WAIT;
            S_WAIT: if (rsp.done) n_state = S_PUSH;
            S_PUSH: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = r_state == S_IDLE;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUSH && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && rsp.done) begin
            r_out_edge <= rsp.edge_value;
        end
        if (r_state == S_PUSH && out_free) begin
            r_out_row <= r_crow;
            r_out_col <= r_ccol;
        end
    end

    logic [EDGE_W-1:0] r_hold_edge;
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && out_free) begin
            r_hold_edge <= r_out_edge;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_col, r_out_row, r_hold_edge};

endmodule
